// File: hw/rtl/mrfc_pkg.sv
// Shared constants, result beat type and CRC byte update for the Modbus RTU frame checker.
`timescale 1ns / 1ps

package mrfc_pkg;

    // Frame limits and CRC-16/MODBUS constants
    localparam int unsigned MAX_FRAME_BYTES_DEF = 256;
    localparam int unsigned MIN_FRAME           = 4;
    localparam logic [15:0] CRC_INIT            = 16'hFFFF;
    localparam logic [15:0] CRC_POLY            = 16'hA001;

    // Item kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Status codes
    typedef enum logic [1:0] {
        STAT_VALID     = 2'd0,
        STAT_TOO_SHORT = 2'd1,
        STAT_CRC_BAD   = 2'd2,
        STAT_OVERLONG  = 2'd3
    } status_t;

    // One result beat as held in the output queue
    typedef struct packed {
        logic       item_kind;
        logic [7:0] payload_byte;
        status_t    status_code;
        logic [7:0] slave_address;
        logic [7:0] function_id;
        logic [7:0] payload_length;
        logic       last_of_run;
    } result_t;

    // Fold one byte into the reflected CRC, one bit per step
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/modbus_rtu_frame_checker_core.sv
// Top level of the Modbus RTU frame checker: CRC check, payload delay line and result queue.
`timescale 1ns / 1ps

// Modbus RTU frame checker.
// Input channel (s_): one received frame byte per beat, s_end_of_frame set on
// the final byte. The CRC-16/MODBUS runs over all bytes but the last two; the
// last two are taken as the received CRC, low byte first.
// Result channel (m_): payload beats (m_item_kind 0) carry frame bytes from
// position 2 on, delayed by two input beats so the CRC bytes never show up.
// The final byte of a frame gives one status beat (m_item_kind 1) with address,
// function code and payload length, or zeros and an error code. m_last_of_run
// marks the last result beat caused by one input beat.
// Ordering: the result beats of an input beat are written to the output queue
// when that beat is taken and leave it in order; a status beat queued behind a
// payload beat follows it.
// Throughput: one input beat per cycle while s_ready is high; the CRC byte
// update is an 8-step combinational chain, and a final byte that yields two
// beats is absorbed by the four-entry output queue.
// Stall: while the receiver holds m_ready low the queue fills, and s_ready
// drops once fewer than two entries are free.
// Reset: the queue empties, CRC returns to 0xFFFF, byte count to zero.
// The frame state also returns to reset after every final byte.
module modbus_rtu_frame_checker_core
    import mrfc_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       s_end_of_frame,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_item_kind,
    output logic [7:0] m_payload_byte,
    output logic [1:0] m_status_code,
    output logic [7:0] m_slave_address,
    output logic [7:0] m_function_id,
    output logic [7:0] m_payload_length,
    output logic       m_last_of_run
);

    localparam int unsigned CNT_RAW = $clog2(MAX_FRAME_BYTES + 2);
    localparam int unsigned CNT_W   = (CNT_RAW < 8) ? 8 : CNT_RAW;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_FRAME);
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
    localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

    // Frame state
    logic [15:0]      crc_reg, crc_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       held0_reg, held0_next;
    logic [7:0]       held1_reg, held1_next;
    logic [7:0]       first_reg, first_next;
    logic [7:0]       second_reg, second_next;

    // Output queue
    result_t          q_mem [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0]  q_count_reg, q_count_next;

    logic       in_beat, out_beat;
    logic       pay_emit;
    logic [15:0] crc_upd;
    logic [CNT_W-1:0] count_inc;
    logic [15:0] rx_crc;
    status_t    status;
    result_t    pay_res, stat_res;
    result_t    wr0_res, wr1_res;
    logic [1:0] push_n;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;
    assign s_ready  = (q_count_reg <= Q_CW'(Q_DEPTH - 2));
    assign m_valid  = (q_count_reg != '0);

    // Advance CRC and delay line for one byte
    always_comb begin
        crc_upd   = crc_byte(crc_reg, held0_reg);
        pay_emit  = (count_reg >= CNT_MIN);
        count_inc = (count_reg <= CNT_MAX) ? count_reg + CNT_ONE : count_reg;
        crc_next  = (count_reg >= CNT_TWO) ? crc_upd : crc_reg;
        held0_next  = held1_reg;
        held1_next  = s_rx_byte;
        first_next  = (count_reg == '0) ? s_rx_byte : first_reg;
        second_next = (count_reg == CNT_ONE) ? s_rx_byte : second_reg;
        count_next  = count_inc;
        rx_crc      = {s_rx_byte, held1_reg};

        // Check the frame on its final byte
        priority if (count_inc < CNT_MIN) begin
            status = STAT_TOO_SHORT;
        end else if (count_inc > CNT_MAX) begin
            status = STAT_OVERLONG;
        end else if (rx_crc != crc_next) begin
            status = STAT_CRC_BAD;
        end else begin
            status = STAT_VALID;
        end

        pay_res = '{item_kind: KIND_PAYLOAD, payload_byte: held0_reg, status_code: STAT_VALID,
                    slave_address: 8'h00, function_id: 8'h00, payload_length: 8'h00,
                    last_of_run: !s_end_of_frame};
        stat_res = '{item_kind: KIND_STATUS, payload_byte: 8'h00, status_code: status,
                     slave_address: (status == STAT_VALID) ? first_next : 8'h00,
                     function_id: (status == STAT_VALID) ? second_next : 8'h00,
                     payload_length: (status == STAT_VALID) ?
                                     8'((count_inc - CNT_MIN) & CNT_W'(8'hFF)) : 8'h00,
                     last_of_run: 1'b1};

        wr0_res = pay_emit ? pay_res : stat_res;
        wr1_res = stat_res;
        push_n  = in_beat ? ({1'b0, pay_emit} + {1'b0, s_end_of_frame}) : 2'd0;
        q_count_next = q_count_reg + Q_CW'(push_n) - Q_CW'(out_beat);
    end

    // Hold frame state; drop back to reset after the final byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg    <= CRC_INIT;
            count_reg  <= '0;
            held0_reg  <= 8'h00;
            held1_reg  <= 8'h00;
            first_reg  <= 8'h00;
            second_reg <= 8'h00;
        end else if (in_beat) begin
            if (s_end_of_frame) begin
                crc_reg    <= CRC_INIT;
                count_reg  <= '0;
                held0_reg  <= 8'h00;
                held1_reg  <= 8'h00;
                first_reg  <= 8'h00;
                second_reg <= 8'h00;
            end else begin
                crc_reg    <= crc_next;
                count_reg  <= count_next;
                held0_reg  <= held0_next;
                held1_reg  <= held1_next;
                first_reg  <= first_next;
                second_reg <= second_next;
            end
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
        end else begin
            wr_ptr_reg  <= wr_ptr_reg + Q_AW'(push_n);
            rd_ptr_reg  <= rd_ptr_reg + Q_AW'(out_beat);
            q_count_reg <= q_count_next;
        end
    end

    // Write up to two result beats per input beat
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_mem[wr_ptr_reg] <= wr0_res;
        end
        if (push_n == 2'd2) begin
            q_mem[wr_ptr_reg + Q_AW'(1)] <= wr1_res;
        end
    end

    assign m_item_kind      = q_mem[rd_ptr_reg].item_kind;
    assign m_payload_byte   = q_mem[rd_ptr_reg].payload_byte;
    assign m_status_code    = q_mem[rd_ptr_reg].status_code;
    assign m_slave_address  = q_mem[rd_ptr_reg].slave_address;
    assign m_function_id    = q_mem[rd_ptr_reg].function_id;
    assign m_payload_length = q_mem[rd_ptr_reg].payload_length;
    assign m_last_of_run    = q_mem[rd_ptr_reg].last_of_run;

    // Queue never overflows
    a_q_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count_reg <= Q_CW'(Q_DEPTH))
        else $error("result queue over depth");

    // Byte count saturates one past the frame limit
    a_cnt_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX + CNT_ONE)
        else $error("byte count past saturation");

    // Final byte restarts frame state
    a_eof_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && s_end_of_frame) |=> (count_reg == '0 && crc_reg == CRC_INIT))
        else $error("frame state not restarted after final byte");

    // Final byte pushes a status beat last
    a_eof_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && s_end_of_frame) |-> (push_n != 2'd0))
        else $error("final byte produced no status beat");

endmodule

// File: tb/mrfc_frame_checker.sv
// Scoreboard for the Modbus RTU frame checker: watches both channels, predicts and compares beats.
`timescale 1ns / 1ps

module mrfc_frame_checker
    import mrfc_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       s_end_of_frame,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_item_kind,
    input  logic [7:0] m_payload_byte,
    input  logic [1:0] m_status_code,
    input  logic [7:0] m_slave_address,
    input  logic [7:0] m_function_id,
    input  logic [7:0] m_payload_length,
    input  logic       m_last_of_run,
    output int         fail_count,
    output int         beats_pending
);

    // Predicted frame state
    logic [15:0] frame_crc;
    int unsigned frame_bytes;
    logic [7:0]  delay_line [0:1];
    logic [7:0]  addr_byte;
    logic [7:0]  func_byte;

    result_t expected_beats [$];
    int      mismatches = 0;

    // Bit-serial CRC-16/MODBUS: feed LSB first, xor the reflected poly on feedback
    function automatic logic [15:0] fold_crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ b[k];
            c  = c >> 1;
            if (fb) begin
                c = c ^ 16'hA001;
            end
        end
        return c;
    endfunction

    task automatic restart_frame();
        frame_crc     = 16'hFFFF;
        frame_bytes   = 0;
        delay_line[0] = 8'h00;
        delay_line[1] = 8'h00;
        addr_byte     = 8'h00;
        func_byte     = 8'h00;
    endtask

    // Advance the frame state by one input beat and queue the beats it causes
    task automatic predict_frame_step(input logic [7:0] b, input logic eof);
        result_t     beats [0:1];
        int          n;
        status_t     st;
        logic [7:0]  oldest;
        logic [15:0] rx_crc;
        n = 0;
        beats[0] = '0;
        beats[1] = '0;

        // Retire the oldest held byte into the CRC; emit it past the header
        if (frame_bytes >= 2) begin
            oldest    = delay_line[0];
            frame_crc = fold_crc_byte(frame_crc, oldest);
            if (frame_bytes >= 4) begin
                beats[n].item_kind    = KIND_PAYLOAD;
                beats[n].payload_byte = oldest;
                n++;
            end
        end
        delay_line[0] = delay_line[1];
        delay_line[1] = b;

        if (frame_bytes == 0) begin
            addr_byte = b;
        end else if (frame_bytes == 1) begin
            func_byte = b;
        end
        // Saturate one past the limit
        if (frame_bytes <= MAX_FRAME_BYTES) begin
            frame_bytes++;
        end

        // Close the frame with a status beat
        if (eof) begin
            rx_crc = {delay_line[1], delay_line[0]};
            if (frame_bytes < MIN_FRAME) begin
                st = STAT_TOO_SHORT;
            end else if (frame_bytes > MAX_FRAME_BYTES) begin
                st = STAT_OVERLONG;
            end else if (rx_crc == frame_crc) begin
                st = STAT_VALID;
            end else begin
                st = STAT_CRC_BAD;
            end
            beats[n].item_kind   = KIND_STATUS;
            beats[n].status_code = st;
            if (st == STAT_VALID) begin
                beats[n].slave_address  = addr_byte;
                beats[n].function_id    = func_byte;
                beats[n].payload_length = 8'(frame_bytes - MIN_FRAME);
            end
            n++;
            restart_frame();
        end

        for (int i = 0; i < n; i++) begin
            beats[i].last_of_run = (i == n - 1);
            expected_beats.push_back(beats[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] expv,
                               input logic [7:0] actv);
        if (expv !== actv) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, expv, actv);
        end
    endtask

    // Compare one result beat against the oldest expectation
    task automatic check_result_beat();
        result_t want;
        if (expected_beats.size() == 0) begin
            mismatches++;
            $display("%0t: result beat with nothing expected (kind %0d, byte 0x%0h, status %0d)",
                     $time, m_item_kind, m_payload_byte, m_status_code);
        end else begin
            want = expected_beats.pop_front();
            check_field("item_kind", {7'b0, want.item_kind}, {7'b0, m_item_kind});
            check_field("payload_byte", want.payload_byte, m_payload_byte);
            check_field("status_code", {6'b0, want.status_code}, {6'b0, m_status_code});
            check_field("slave_address", want.slave_address, m_slave_address);
            check_field("function_id", want.function_id, m_function_id);
            check_field("payload_length", want.payload_length, m_payload_length);
            check_field("last_of_run", {7'b0, want.last_of_run}, {7'b0, m_last_of_run});
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_frame();
            expected_beats.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_result_beat();
            end
            if (s_valid && s_ready) begin
                predict_frame_step(s_rx_byte, s_end_of_frame);
            end
        end
        fail_count    <= mismatches;
        beats_pending <= expected_beats.size();
    end

endmodule

// File: tb/modbus_rtu_frame_checker_core_tb.sv
// Testbench top for the Modbus RTU frame checker: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

module modbus_rtu_frame_checker_core_tb;
    import mrfc_pkg::*;

    localparam int unsigned FRAME_LIMIT  = MAX_FRAME_BYTES_DEF;
    localparam int          BUF_DEPTH    = 300;
    localparam int          ITEMS_TARGET = 1550;
    localparam int          STALL_LIMIT  = 5000;
    localparam int          IDLE_PCT     = 23;

    logic       aclk;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte      = 8'h00;
    logic       s_end_of_frame = 1'b0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic       m_item_kind;
    logic [7:0] m_payload_byte;
    logic [1:0] m_status_code;
    logic [7:0] m_slave_address;
    logic [7:0] m_function_id;
    logic [7:0] m_payload_length;
    logic       m_last_of_run;

    int fail_count;
    int beats_pending;

    logic       no_idle     = 1'b0;
    int         idle_cycles = 0;
    int         bytes_sent  = 0;
    int         frames_good = 0;
    int         frames_crc_bad = 0;
    int         frames_short = 0;
    int         frames_overlong = 0;
    int         frames_noise = 0;
    logic [7:0] frame_buf [0:BUF_DEPTH-1];

    modbus_rtu_frame_checker_core #(
        .MAX_FRAME_BYTES(FRAME_LIMIT)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .s_end_of_frame  (s_end_of_frame),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item_kind     (m_item_kind),
        .m_payload_byte  (m_payload_byte),
        .m_status_code   (m_status_code),
        .m_slave_address (m_slave_address),
        .m_function_id   (m_function_id),
        .m_payload_length(m_payload_length),
        .m_last_of_run   (m_last_of_run)
    );

    mrfc_frame_checker #(
        .MAX_FRAME_BYTES(FRAME_LIMIT)
    ) i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .s_end_of_frame  (s_end_of_frame),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item_kind     (m_item_kind),
        .m_payload_byte  (m_payload_byte),
        .m_status_code   (m_status_code),
        .m_slave_address (m_slave_address),
        .m_function_id   (m_function_id),
        .m_payload_length(m_payload_length),
        .m_last_of_run   (m_last_of_run),
        .fail_count      (fail_count),
        .beats_pending   (beats_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Throttle the result side at random, except during the quiet stretch
    always @(negedge aclk) begin
        m_ready = no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // Count cycles with no beat on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("modbus_rtu_frame_checker_core verification failed");
        $finish;
    end

    // Drive one input beat; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eof);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_rx_byte      = b;
        s_end_of_frame = eof;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(frame_buf[i], i == len - 1);
        end
    endtask

    // Append the CRC, low byte first, over all but the last two slots
    task automatic put_crc(input int len);
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int i = 0; i < len - 2; i++) begin
            crc = crc_byte(crc, frame_buf[i]);
        end
        frame_buf[len-2] = crc[7:0];
        frame_buf[len-1] = crc[15:8];
    endtask

    task automatic fill_random(input int len);
        for (int i = 0; i < len; i++) begin
            frame_buf[i] = 8'($urandom_range(255));
        end
    endtask

    task automatic send_good_frame(input int len);
        fill_random(len);
        put_crc(len);
        send_frame(len);
        if (len > FRAME_LIMIT) begin
            frames_overlong++;
        end else begin
            frames_good++;
        end
    endtask

    task automatic send_bad_crc_frame(input int len);
        fill_random(len);
        put_crc(len);
        frame_buf[len - 1 - $urandom_range(1)] ^= 8'(8'h01 << $urandom_range(7));
        send_frame(len);
        frames_crc_bad++;
    endtask

    initial begin
        int pick;
        int drain;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: all-ones header, minimal frame
        frame_buf[0] = 8'hFF;
        frame_buf[1] = 8'hFF;
        put_crc(4);
        send_frame(4);
        // All-zero header, minimal frame
        frame_buf[0] = 8'h00;
        frame_buf[1] = 8'h00;
        put_crc(4);
        send_frame(4);
        frames_good += 2;
        // Single-byte frame, too short
        frame_buf[0] = 8'hFF;
        send_frame(1);
        // Three-byte frame, too short
        frame_buf[0] = 8'h00;
        frame_buf[1] = 8'h80;
        frame_buf[2] = 8'h7F;
        send_frame(3);
        frames_short += 2;
        // CRC mismatch on a short payload
        frame_buf[0] = 8'h11;
        frame_buf[1] = 8'h06;
        frame_buf[2] = 8'hAA;
        put_crc(5);
        frame_buf[3] ^= 8'h01;
        send_frame(5);
        frames_crc_bad++;
        // Valid frame with payload extremes
        frame_buf[0] = 8'h01;
        frame_buf[1] = 8'h03;
        frame_buf[2] = 8'h00;
        frame_buf[3] = 8'hFF;
        put_crc(6);
        send_frame(6);
        frames_good++;
        // Two-byte frame, too short
        frame_buf[0] = 8'hFE;
        frame_buf[1] = 8'h01;
        send_frame(2);
        frames_short++;

        // Largest legal frame, then an overlong one that saturates the count
        send_good_frame(FRAME_LIMIT);
        send_good_frame(FRAME_LIMIT + 4);

        // Random: mostly well-formed frames, some broken ones and noise
        while (bytes_sent < ITEMS_TARGET) begin
            no_idle = (bytes_sent >= 900) && (bytes_sent < 1150);
            pick = $urandom_range(99);
            if (pick < 65) begin
                send_good_frame($urandom_range(24, 4));
            end else if (pick < 77) begin
                send_bad_crc_frame($urandom_range(24, 4));
            end else if (pick < 87) begin
                fill_random(3);
                send_frame($urandom_range(3, 1));
                frames_short++;
            end else begin
                fill_random(40);
                send_frame($urandom_range(40, 1));
                frames_noise++;
            end
        end
        s_valid = 1'b0;
        no_idle = 1'b0;

        // Drain the result side, then allow for the output latency
        while (beats_pending != 0) @(posedge aclk);
        drain = 10;
        repeat (drain) @(posedge aclk);

        $display("covered %0d input bytes: %0d good frames, %0d bad CRC, %0d too short,",
                 bytes_sent, frames_good, frames_crc_bad, frames_short);
        $display("%0d overlong and %0d noise frames", frames_overlong, frames_noise);
        if (fail_count == 0 && beats_pending == 0) begin
            $display("modbus_rtu_frame_checker_core verification clean");
        end else begin
            $display("modbus_rtu_frame_checker_core verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/mrfc_pkg.sv
hw/rtl/modbus_rtu_frame_checker_core.sv
tb/mrfc_frame_checker.sv
tb/modbus_rtu_frame_checker_core_tb.sv
